### src/gdc_pkg.sv
// Shared constants, types and codes of the grid ray caster.
`default_nettype none

package gdc_pkg;

    // Geometry and angle configuration.
    localparam int MAP_DIM    = 64;
    localparam int TILE_SHIFT = 6;
    localparam int ANGLE_BITS = 12;

    localparam int MAP_BITS    = $clog2(MAP_DIM);
    localparam int ADDR_BITS   = 2 * MAP_BITS;
    localparam int CELL_BITS   = MAP_BITS + 2;
    localparam int TILE        = 1 << TILE_SHIFT;
    localparam int GAP_BITS    = TILE_SHIFT + 1;
    localparam int DIV_SHIFT   = 22;
    localparam int DIV_BITS    = GAP_BITS + DIV_SHIFT;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
    localparam int TRIG_BITS   = 15;
    localparam int TRIG_FRAC   = 14;
    localparam int DIST_BITS   = 31;
    localparam int OUT_BITS    = 24;
    localparam int PROD_BITS   = OUT_BITS + TRIG_BITS;
    localparam int STEP_LIMIT  = 2 * MAP_DIM + 2;
    localparam int STEP_BITS   = $clog2(STEP_LIMIT + 1);
    localparam int X_SHIFT     = 17 - ANGLE_BITS;
    localparam int FIELD_BITS  = 6;
    localparam int CFG_BITS    = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic signed [CELL_BITS-1:0] t_cell;
    typedef logic [DIST_BITS-1:0]        t_dist;
    typedef logic [TRIG_BITS-1:0]        t_trig;
    typedef logic [ANGLE_BITS-1:0]       t_angle;
    typedef logic [ADDR_BITS-1:0]        t_addr;
    typedef logic [MAP_BITS:0]           t_dim;
    typedef logic [OUT_BITS-1:0]         t_out;
    typedef logic [GAP_BITS-1:0]         t_gap;
    typedef logic [FIELD_BITS-1:0]       t_field;
    typedef logic [TILE_SHIFT-1:0]       t_frac;
    typedef logic [CFG_BITS-1:0]         t_cfg;
    typedef logic [STEP_BITS-1:0]        t_steps;
    typedef logic [ANGLE_BITS-2:0]       t_phase;

    localparam t_angle QUARTER_A = t_angle'(1 << (ANGLE_BITS - 2));
    localparam t_angle HALF_A    = t_angle'(2 << (ANGLE_BITS - 2));
    localparam t_angle THREEQ_A  = t_angle'(3 << (ANGLE_BITS - 2));
    localparam t_phase QUARTER_P = t_phase'(1 << (ANGLE_BITS - 2));

    localparam t_dist DIST_MAX = '1;
    localparam t_out  OUT_MAX  = '1;
    localparam t_cfg  CFG_DIM_RESET = t_cfg'(MAP_DIM);

    // Polynomial coefficients of the quarter-wave sine.
    localparam logic [15:0] K_SIN_A = 16'd51472;
    localparam logic [15:0] K_SIN_B = 16'd21024;
    localparam logic [15:0] K_SIN_C = 16'd2320;

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_LEFT  = 2'd2;

    // Wall face codes.
    localparam logic [1:0] FACE_EAST  = 2'd0;
    localparam logic [1:0] FACE_WEST  = 2'd1;
    localparam logic [1:0] FACE_NORTH = 2'd2;
    localparam logic [1:0] FACE_SOUTH = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    // One classified item, passed from the front to the back.
    typedef struct packed {
        logic   kind;
        t_field cell_col;
        t_field cell_row;
        logic   cell_is_wall;
        t_cell  mx0;
        t_cell  my0;
        t_frac  fx;
        t_frac  fy;
        t_angle a;
        t_trig  sn_mag;
        t_trig  cs_mag;
        t_trig  cc_mag;
        logic   cc_neg;
    } t_item;

endpackage

`default_nettype wire

### src/grid_ray_dda_caster_unit.sv
// Top level of the grid ray caster: configuration registers and the front/back pair.
// A cell write passes through the front, the queue and the back to the output register; a cast
// adds the trigonometry, up to four serial divisions and a grid walk, cell by cell.
// Throughput: the back end takes one item at a time; the front classifies the next one
// meanwhile through a two-entry queue. Reset clears the whole map in a sweep with
// input stalled; configuration writes are taken at any time.
`default_nettype none

module grid_ray_dda_caster_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic          i_kind,
    input  wire logic [5:0]    i_cell_col,
    input  wire logic [5:0]    i_cell_row,
    input  wire logic          i_cell_is_wall,
    input  wire logic [11:0]   i_player_x,
    input  wire logic [11:0]   i_player_y,
    input  wire logic [13:0]   i_ray_angle,
    input  wire logic [11:0]   i_view_angle,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [1:0]         o_status,
    output logic [5:0]         o_hit_col,
    output logic [5:0]         o_hit_row,
    output logic               o_hit_side,
    output logic [1:0]         o_wall_face,
    output logic [23:0]        o_raw_distance,
    output logic [23:0]        o_corrected_distance,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_index,
    input  wire logic [6:0]    i_cfg_data
);

    gdc_pkg::t_cfg   r_cols, r_rows;
    gdc_pkg::t_dim   cols, rows;
    gdc_pkg::t_item  front_item, queue_item;
    logic            push, pop, full, empty, clearing;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= gdc_pkg::CFG_DIM_RESET;
            r_rows <= gdc_pkg::CFG_DIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                gdc_pkg::CFG_COLUMNS: r_cols <= i_cfg_data;
                gdc_pkg::CFG_ROWS:    r_rows <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Used map size, limited to the stored map.
    always_comb begin
        cols = (int'(r_cols) > gdc_pkg::MAP_DIM) ? gdc_pkg::t_dim'(gdc_pkg::MAP_DIM)
                                                 : gdc_pkg::t_dim'(r_cols);
        rows = (int'(r_rows) > gdc_pkg::MAP_DIM) ? gdc_pkg::t_dim'(gdc_pkg::MAP_DIM)
                                                 : gdc_pkg::t_dim'(r_rows);
    end

    gdc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_cell_col     (i_cell_col),
        .i_cell_row     (i_cell_row),
        .i_cell_is_wall (i_cell_is_wall),
        .i_player_x     (i_player_x),
        .i_player_y     (i_player_y),
        .i_ray_angle    (i_ray_angle),
        .i_view_angle   (i_view_angle),
        .i_hold         (clearing),
        .i_full         (full),
        .o_push         (push),
        .o_item         (front_item)
    );

    gdc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_empty (empty)
    );

    gdc_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_empty              (empty),
        .o_pop                (pop),
        .i_item               (queue_item),
        .i_cols               (cols),
        .i_rows               (rows),
        .o_clearing           (clearing),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_hit_col            (o_hit_col),
        .o_hit_row            (o_hit_row),
        .o_hit_side           (o_hit_side),
        .o_wall_face          (o_wall_face),
        .o_raw_distance       (o_raw_distance),
        .o_corrected_distance (o_corrected_distance)
    );

endmodule

`default_nettype wire

### src/gdc_front.sv
// Front end: accepts items and works out the trigonometry of each ray.
`default_nettype none

module gdc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic          i_kind,
    input  wire logic [5:0]    i_cell_col,
    input  wire logic [5:0]    i_cell_row,
    input  wire logic          i_cell_is_wall,
    input  wire logic [11:0]   i_player_x,
    input  wire logic [11:0]   i_player_y,
    input  wire logic [13:0]   i_ray_angle,
    input  wire logic [11:0]   i_view_angle,
    input  wire logic          i_hold,
    input  wire logic          i_full,
    output logic               o_push,
    output gdc_pkg::t_item     o_item
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_TRIG = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    localparam logic [1:0] TI_SIN  = 2'd0;
    localparam logic [1:0] TI_COS  = 2'd1;
    localparam logic [1:0] TI_VIEW = 2'd2;

    localparam logic [1:0] SP_SQUARE = 2'd0;
    localparam logic [1:0] SP_INNER  = 2'd1;
    localparam logic [1:0] SP_OUTER  = 2'd2;
    localparam logic [1:0] SP_FINAL  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [1:0]      r_ti, n_ti;
    logic [1:0]      r_step, n_step;
    gdc_pkg::t_item  r_item;
    gdc_pkg::t_angle r_ca;
    logic [15:0]     r_x, r_x2, r_t;
    logic            r_neg;

    logic            accept;
    logic [31:0]     ray_ext, view_ext, ca_diff;
    gdc_pkg::t_angle ph;
    gdc_pkg::t_phase pq;
    logic [15:0]     x_val, mul_a, mul_b;
    logic [31:0]     prod;

    assign o_in_stall = (r_state != F_IDLE) || i_hold;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_item     = r_item;

    // Ray and view-offset angles, reduced to one turn.
    always_comb begin
        ray_ext  = {{18{i_ray_angle[13]}}, i_ray_angle};
        view_ext = {20'd0, i_view_angle};
        ca_diff  = view_ext - ray_ext;
    end

    // Phase of the sine being evaluated, folded into the first quadrant.
    always_comb begin
        case (r_ti)
            TI_SIN:  ph = r_item.a;
            TI_COS:  ph = r_item.a + gdc_pkg::QUARTER_A;
            default: ph = r_ca + gdc_pkg::QUARTER_A;
        endcase
        pq = {1'b0, ph[gdc_pkg::ANGLE_BITS-3:0]};
        if (ph[gdc_pkg::ANGLE_BITS-2]) begin
            pq = gdc_pkg::QUARTER_P - pq;
        end
        x_val = 16'(pq) << gdc_pkg::X_SHIFT;
    end

    // One shared multiplier serves the four polynomial steps.
    always_comb begin
        case (r_step)
            SP_SQUARE: begin
                mul_a = x_val;
                mul_b = x_val;
            end
            SP_INNER: begin
                mul_a = gdc_pkg::K_SIN_C;
                mul_b = r_x2;
            end
            SP_OUTER: begin
                mul_a = r_t;
                mul_b = r_x2;
            end
            default: begin
                mul_a = r_x;
                mul_b = r_t;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // Sequencer: three sines of four steps each.
    always_comb begin
        n_state = r_state;
        n_ti    = r_ti;
        n_step  = r_step;
        case (r_state)
            F_IDLE: begin
                n_ti   = TI_SIN;
                n_step = SP_SQUARE;
                if (accept) begin
                    n_state = (i_kind == gdc_pkg::KIND_CAST) ? F_TRIG : F_PUSH;
                end
            end
            F_TRIG: begin
                if (r_step == SP_FINAL) begin
                    n_step = SP_SQUARE;
                    if (r_ti == TI_VIEW) begin
                        n_state = F_PUSH;
                    end else begin
                        n_ti = r_ti + 2'd1;
                    end
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_ti    <= TI_SIN;
            r_step  <= SP_SQUARE;
        end else begin
            r_state <= n_state;
            r_ti    <= n_ti;
            r_step  <= n_step;
        end
    end

    // Item capture and polynomial datapath.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.kind         <= i_kind;
            r_item.cell_col     <= i_cell_col;
            r_item.cell_row     <= i_cell_row;
            r_item.cell_is_wall <= i_cell_is_wall;
            r_item.mx0          <= gdc_pkg::t_cell'(i_player_x >> gdc_pkg::TILE_SHIFT);
            r_item.my0          <= gdc_pkg::t_cell'(i_player_y >> gdc_pkg::TILE_SHIFT);
            r_item.fx           <= i_player_x[gdc_pkg::TILE_SHIFT-1:0];
            r_item.fy           <= i_player_y[gdc_pkg::TILE_SHIFT-1:0];
            r_item.a            <= ray_ext[gdc_pkg::ANGLE_BITS-1:0];
            r_ca                <= ca_diff[gdc_pkg::ANGLE_BITS-1:0];
        end
        if (r_state == F_TRIG) begin
            case (r_step)
                SP_SQUARE: begin
                    r_x   <= x_val;
                    r_neg <= ph[gdc_pkg::ANGLE_BITS-1];
                    r_x2  <= prod[30:15];
                end
                SP_INNER: r_t <= gdc_pkg::K_SIN_B - prod[30:15];
                SP_OUTER: r_t <= gdc_pkg::K_SIN_A - prod[30:15];
                default: begin
                    case (r_ti)
                        TI_SIN: r_item.sn_mag <= prod[30:16];
                        TI_COS: r_item.cs_mag <= prod[30:16];
                        default: begin
                            r_item.cc_mag <= prod[30:16];
                            r_item.cc_neg <= r_neg;
                        end
                    endcase
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### src/gdc_fifo.sv
// Short queue of classified items between the front and the back.
`default_nettype none

module gdc_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  gdc_pkg::t_item      i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output gdc_pkg::t_item      o_item,
    output logic                o_empty
);

    gdc_pkg::t_item                  r_mem [gdc_pkg::QUEUE_DEPTH];
    logic [gdc_pkg::QPTR_BITS-1:0]   r_wp, r_rp;
    logic [gdc_pkg::QPTR_BITS:0]     r_cnt;

    assign o_full  = (r_cnt == (gdc_pkg::QPTR_BITS + 1)'(gdc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

### src/gdc_back.sv
// Back end: wall map, distance divider, grid walk and fisheye correction.
`default_nettype none

module gdc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    output logic               o_pop,
    input  gdc_pkg::t_item     i_item,
    input  gdc_pkg::t_dim      i_cols,
    input  gdc_pkg::t_dim      i_rows,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [1:0]         o_status,
    output logic [5:0]         o_hit_col,
    output logic [5:0]         o_hit_row,
    output logic               o_hit_side,
    output logic [1:0]         o_wall_face,
    output logic [23:0]        o_raw_distance,
    output logic [23:0]        o_corrected_distance
);

    localparam logic [3:0] B_CLEAR = 4'd0;
    localparam logic [3:0] B_IDLE  = 4'd1;
    localparam logic [3:0] B_DLOAD = 4'd2;
    localparam logic [3:0] B_DIV   = 4'd3;
    localparam logic [3:0] B_CHECK = 4'd4;
    localparam logic [3:0] B_TEST  = 4'd5;
    localparam logic [3:0] B_MUL   = 4'd6;
    localparam logic [3:0] B_FIN   = 4'd7;
    localparam logic [3:0] B_DONE  = 4'd8;

    localparam logic [1:0] DI_SDX = 2'd0;
    localparam logic [1:0] DI_SDY = 2'd1;
    localparam logic [1:0] DI_DDX = 2'd2;
    localparam logic [1:0] DI_DDY = 2'd3;

    logic [3:0]                           r_st, n_st;
    logic                                 r_ov, n_ov;
    gdc_pkg::t_addr                       r_clr;
    gdc_pkg::t_item                       r_item;
    logic [1:0]                           r_di;
    logic [gdc_pkg::DIV_CNT_BITS-1:0]     r_cnt;
    gdc_pkg::t_trig                       r_rem;
    logic [gdc_pkg::DIV_BITS-1:0]         r_quo;
    gdc_pkg::t_dist                       r_sdx, r_sdy, r_ddx, r_ddy;
    gdc_pkg::t_cell                       r_mx, r_my;
    logic                                 r_side;
    gdc_pkg::t_steps                      r_n;
    logic                                 r_rd;
    gdc_pkg::t_out                        r_raw, r_corr;
    logic [gdc_pkg::PROD_BITS-1:0]        r_prod;
    logic [1:0]                           r_status, r_face;
    logic                                 r_wall_mem [1 << gdc_pkg::ADDR_BITS];

    logic                                 stx_neg, sty_neg, load_out, out_of_map;
    logic                                 we, wd, item_in_range;
    gdc_pkg::t_addr                       wa, ra;
    gdc_pkg::t_gap                        gap;
    gdc_pkg::t_trig                       dsr;
    logic [gdc_pkg::TRIG_BITS:0]          sh, sh_diff;
    logic                                 qbit;
    logic [gdc_pkg::DIV_BITS-1:0]         quo_next;
    gdc_pkg::t_trig                       rem_next;
    logic [gdc_pkg::DIST_BITS:0]          sum_x, sum_y;
    gdc_pkg::t_dist                       sat_x, sat_y, sd, dd, raw_full;
    logic [1:0]                           face;

    assign o_clearing  = (r_st == B_CLEAR);
    assign o_pop       = (r_st == B_IDLE) && !i_empty;
    assign o_out_valid = r_ov;
    assign load_out    = (r_st == B_DONE) && (!r_ov || !i_out_stall);

    // Ray direction signs.
    always_comb begin
        stx_neg = (r_item.a > gdc_pkg::QUARTER_A) && (r_item.a < gdc_pkg::THREEQ_A);
        sty_neg = (r_item.a < gdc_pkg::HALF_A);
    end

    // Operands of the current division.
    always_comb begin
        case (r_di)
            DI_SDX: begin
                gap = stx_neg ? {1'b0, r_item.fx}
                              : gdc_pkg::t_gap'(gdc_pkg::TILE) - {1'b0, r_item.fx};
                dsr = r_item.cs_mag;
            end
            DI_SDY: begin
                gap = sty_neg ? {1'b0, r_item.fy}
                              : gdc_pkg::t_gap'(gdc_pkg::TILE) - {1'b0, r_item.fy};
                dsr = r_item.sn_mag;
            end
            DI_DDX: begin
                gap = gdc_pkg::t_gap'(gdc_pkg::TILE);
                dsr = r_item.cs_mag;
            end
            default: begin
                gap = gdc_pkg::t_gap'(gdc_pkg::TILE);
                dsr = r_item.sn_mag;
            end
        endcase
    end

    // One restoring division step per cycle.
    always_comb begin
        sh       = {r_rem, r_quo[gdc_pkg::DIV_BITS-1]};
        sh_diff  = sh - {1'b0, dsr};
        qbit     = (sh >= {1'b0, dsr});
        rem_next = qbit ? sh_diff[gdc_pkg::TRIG_BITS-1:0] : sh[gdc_pkg::TRIG_BITS-1:0];
        quo_next = {r_quo[gdc_pkg::DIV_BITS-2:0], qbit};
    end

    // Saturating side distance sums and the hit distance.
    always_comb begin
        sum_x    = {1'b0, r_sdx} + {1'b0, r_ddx};
        sum_y    = {1'b0, r_sdy} + {1'b0, r_ddy};
        sat_x    = sum_x[gdc_pkg::DIST_BITS] ? gdc_pkg::DIST_MAX
                                             : sum_x[gdc_pkg::DIST_BITS-1:0];
        sat_y    = sum_y[gdc_pkg::DIST_BITS] ? gdc_pkg::DIST_MAX
                                             : sum_y[gdc_pkg::DIST_BITS-1:0];
        sd       = r_side ? r_sdy : r_sdx;
        dd       = r_side ? r_ddy : r_ddx;
        raw_full = (sd > dd) ? sd - dd : '0;
        if (!r_side) begin
            face = ((r_item.a <= gdc_pkg::QUARTER_A) || (r_item.a >= gdc_pkg::THREEQ_A))
                 ? gdc_pkg::FACE_EAST : gdc_pkg::FACE_WEST;
        end else begin
            face = (r_item.a <= gdc_pkg::HALF_A) ? gdc_pkg::FACE_NORTH : gdc_pkg::FACE_SOUTH;
        end
    end

    // Map bounds of the current cell.
    always_comb begin
        out_of_map = r_mx[gdc_pkg::CELL_BITS-1] || r_my[gdc_pkg::CELL_BITS-1]
                  || (int'(r_mx) >= int'(i_cols)) || (int'(r_my) >= int'(i_rows));
        ra = gdc_pkg::t_addr'(int'(r_my) * gdc_pkg::MAP_DIM + int'(r_mx));
    end

    // Map write port: clearing sweep or a cell write item.
    always_comb begin
        item_in_range = (int'(i_item.cell_col) < gdc_pkg::MAP_DIM)
                     && (int'(i_item.cell_row) < gdc_pkg::MAP_DIM);
        if (r_st == B_CLEAR) begin
            we = 1'b1;
            wa = r_clr;
            wd = 1'b0;
        end else begin
            we = o_pop && (i_item.kind == gdc_pkg::KIND_WRITE) && item_in_range;
            wa = gdc_pkg::t_addr'(int'(i_item.cell_row) * gdc_pkg::MAP_DIM
                                  + int'(i_item.cell_col));
            wd = i_item.cell_is_wall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_wall_mem[wa] <= wd;
        end
        r_rd <= r_wall_mem[ra];
    end

    // Control sequence.
    always_comb begin
        n_st    = r_st;
        n_ov    = r_ov;
        case (r_st)
            B_CLEAR: begin
                if (r_clr == '1) begin
                    n_st = B_IDLE;
                end
            end
            B_IDLE: begin
                if (o_pop) begin
                    n_st = (i_item.kind == gdc_pkg::KIND_CAST) ? B_DLOAD : B_DONE;
                end
            end
            B_DLOAD: begin
                if (dsr == '0) begin
                    n_st = (r_di == DI_DDY) ? B_CHECK : B_DLOAD;
                end else begin
                    n_st = B_DIV;
                end
            end
            B_DIV: begin
                if (r_cnt == gdc_pkg::DIV_CNT_BITS'(gdc_pkg::DIV_BITS - 1)) begin
                    n_st = (r_di == DI_DDY) ? B_CHECK : B_DLOAD;
                end
            end
            B_CHECK: n_st = out_of_map ? B_DONE : B_TEST;
            B_TEST: begin
                if (r_rd) begin
                    n_st = B_MUL;
                end else if (r_n == gdc_pkg::t_steps'(gdc_pkg::STEP_LIMIT)) begin
                    n_st = B_DONE;
                end else begin
                    n_st = B_CHECK;
                end
            end
            B_MUL: n_st = B_FIN;
            B_FIN: n_st = B_DONE;
            B_DONE: begin
                if (load_out) begin
                    n_st = B_IDLE;
                end
            end
            default: n_st = B_IDLE;
        endcase
        if (load_out) begin
            n_ov = 1'b1;
        end else if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= B_CLEAR;
            r_ov    <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_st    <= n_st;
            r_ov    <= n_ov;
            if (r_st == B_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_st)
            B_IDLE: begin
                r_item   <= i_item;
                r_di     <= DI_SDX;
                r_n      <= '0;
                r_side   <= 1'b0;
                r_mx     <= i_item.mx0;
                r_my     <= i_item.my0;
                r_status <= (i_item.kind == gdc_pkg::KIND_CAST) ? gdc_pkg::ST_LEFT
                                                                : gdc_pkg::ST_WRITE;
            end
            B_DLOAD: begin
                r_rem <= '0;
                r_cnt <= '0;
                r_quo <= {gap, gdc_pkg::DIV_SHIFT'(0)};
                if (dsr == '0) begin
                    case (r_di)
                        DI_SDX:  r_sdx <= gdc_pkg::DIST_MAX;
                        DI_SDY:  r_sdy <= gdc_pkg::DIST_MAX;
                        DI_DDX:  r_ddx <= gdc_pkg::DIST_MAX;
                        default: r_ddy <= gdc_pkg::DIST_MAX;
                    endcase
                    r_di <= r_di + 2'd1;
                end
            end
            B_DIV: begin
                r_rem <= rem_next;
                r_quo <= quo_next;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == gdc_pkg::DIV_CNT_BITS'(gdc_pkg::DIV_BITS - 1)) begin
                    case (r_di)
                        DI_SDX:  r_sdx <= gdc_pkg::t_dist'(quo_next);
                        DI_SDY:  r_sdy <= gdc_pkg::t_dist'(quo_next);
                        DI_DDX:  r_ddx <= gdc_pkg::t_dist'(quo_next);
                        default: r_ddy <= gdc_pkg::t_dist'(quo_next);
                    endcase
                    r_di <= r_di + 2'd1;
                end
            end
            B_TEST: begin
                if (r_rd) begin
                    r_status <= gdc_pkg::ST_HIT;
                    r_face   <= face;
                    r_raw    <= (raw_full > gdc_pkg::t_dist'(gdc_pkg::OUT_MAX))
                              ? gdc_pkg::OUT_MAX : raw_full[gdc_pkg::OUT_BITS-1:0];
                end else begin
                    r_n <= r_n + 1'b1;
                    if (r_sdx < r_sdy) begin
                        r_sdx  <= sat_x;
                        r_mx   <= stx_neg ? r_mx - gdc_pkg::t_cell'(1)
                                          : r_mx + gdc_pkg::t_cell'(1);
                        r_side <= 1'b0;
                    end else begin
                        r_sdy  <= sat_y;
                        r_my   <= sty_neg ? r_my - gdc_pkg::t_cell'(1)
                                          : r_my + gdc_pkg::t_cell'(1);
                        r_side <= 1'b1;
                    end
                end
            end
            B_MUL: r_prod <= r_raw * r_item.cc_mag;
            B_FIN: begin
                if (r_item.cc_neg || (r_item.cc_mag == '0)) begin
                    r_corr <= '0;
                end else if (r_prod[gdc_pkg::PROD_BITS-1]) begin
                    r_corr <= gdc_pkg::OUT_MAX;
                end else begin
                    r_corr <= r_prod[gdc_pkg::PROD_BITS-2:gdc_pkg::TRIG_FRAC];
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_status <= r_status;
            if (r_status == gdc_pkg::ST_HIT) begin
                o_hit_col            <= gdc_pkg::t_field'(r_mx);
                o_hit_row            <= gdc_pkg::t_field'(r_my);
                o_hit_side           <= r_side;
                o_wall_face          <= r_face;
                o_raw_distance       <= r_raw;
                o_corrected_distance <= r_corr;
            end else begin
                o_hit_col            <= '0;
                o_hit_row            <= '0;
                o_hit_side           <= 1'b0;
                o_wall_face          <= '0;
                o_raw_distance       <= '0;
                o_corrected_distance <= '0;
            end
        end
    end

    // No result is offered while the map is still being cleared.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_CLEAR) |-> !r_ov)
        else $error("result valid during map clear");

    // A cell check always leads to a map test or a finished cast.
    a_check_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_CHECK) |=> ((r_st == B_TEST) || (r_st == B_DONE)))
        else $error("grid walk left the check step unexpectedly");

    // A wall seen by the test marks the cast as a hit.
    a_wall_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_st == B_TEST) && r_rd) |=> (r_status == gdc_pkg::ST_HIT))
        else $error("wall found but status is not a hit");

    // A hit cell has non-negative map coordinates.
    a_hit_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_st == B_DONE) && (r_status == gdc_pkg::ST_HIT))
            |-> (!r_mx[gdc_pkg::CELL_BITS-1] && !r_my[gdc_pkg::CELL_BITS-1]))
        else $error("hit cell outside the map");

endmodule

`default_nettype wire
